// ===== design/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrd_pkg
// types, codes and the crc-32c byte update shared by the record deframer
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned IN_USER_W   = 1;
  localparam int unsigned OUT_USER_W  = 4;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MAX_CFG_W   = 25;
  localparam int unsigned HDR_CNT_W   = 3;
  localparam int unsigned LEN_FIELD_W = 32;

  // reset value of max_record_bytes and default hard ceiling
  localparam int unsigned MAX_RECORD_DEFAULT = 16777216;
  localparam int unsigned MAX_CFG_VALUE      = (1 << MAX_CFG_W) - 1;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // register select on paddr[2]
  localparam logic REG_MAX_RECORD = 1'b0;
  localparam logic REG_SKIP       = 1'b1;

  // input kind carried in tuser
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOL  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SIZE    = 3'd1,
    ST_CRC     = 3'd2,
    ST_SKIPPED = 3'd3,
    ST_TRUNC   = 3'd4,
    ST_EOL     = 3'd5
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] payload_byte;
    logic              payload_valid;
    logic              record_end;
    status_t           status;
  } lrd_result_t;

  typedef struct packed {
    logic [MAX_CFG_W-1:0] max_record_bytes;
    logic                 skip_corrupt;
  } lrd_cfg_t;

  // reflected crc-32c, one byte, eight shift steps
  function automatic logic [31:0] crc32c_byte(logic [31:0] crc, logic [DATA_W-1:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/lrd_parser.sv =====
// ----------------------------------------------------------------------------
// lrd_parser
// header collection, length check, payload count and running crc-32c
// ----------------------------------------------------------------------------
module lrd_parser #(
  parameter int unsigned MAX_RECORD_LIMIT = lrd_pkg::MAX_RECORD_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        word_fire,
  input  logic                        mode,
  input  logic [lrd_pkg::DATA_W-1:0]  data_byte,
  input  lrd_pkg::lrd_cfg_t           cfg,
  output logic                        res_valid,
  output lrd_pkg::lrd_result_t        res
);
  import lrd_pkg::*;

  // the register can never exceed its own width, so neither can a length
  localparam int unsigned EFF_LIMIT =
    (MAX_RECORD_LIMIT < MAX_CFG_VALUE) ? MAX_RECORD_LIMIT : MAX_CFG_VALUE;
  localparam int unsigned LEN_W = $clog2(EFF_LIMIT + 1);
  localparam logic [LEN_FIELD_W-1:0] LIMIT_W = LEN_FIELD_W'(MAX_RECORD_LIMIT);

  logic                   in_payload_r, in_payload_nxt;
  logic [HDR_CNT_W-1:0]   header_count_r, header_count_nxt;
  logic [LEN_FIELD_W-1:0] record_length_r, record_length_nxt;
  logic [31:0]            stored_crc_r, stored_crc_nxt;
  logic [31:0]            running_crc_r, running_crc_nxt;
  logic [LEN_W-1:0]       bytes_left_r, bytes_left_nxt;

  logic [LEN_FIELD_W-1:0] lim;
  logic [31:0]            crc_upd;
  logic [4:0]             sh;

  always_comb begin
    lim = {{(LEN_FIELD_W-MAX_CFG_W){1'b0}}, cfg.max_record_bytes};
    if (lim > LIMIT_W) begin
      lim = LIMIT_W;
    end
  end

  assign crc_upd = crc32c_byte(running_crc_r, data_byte);
  assign sh      = {header_count_r[1:0], 3'b000};

  always_comb begin
    in_payload_nxt    = in_payload_r;
    header_count_nxt  = header_count_r;
    record_length_nxt = record_length_r;
    stored_crc_nxt    = stored_crc_r;
    running_crc_nxt   = running_crc_r;
    bytes_left_nxt    = bytes_left_r;
    res_valid         = 1'b0;
    res               = '{payload_byte: '0, payload_valid: 1'b0,
                          record_end: 1'b1, status: ST_OK};
    if (word_fire) begin
      if (mode == MODE_EOL) begin
        in_payload_nxt   = 1'b0;
        header_count_nxt = '0;
        bytes_left_nxt   = '0;
        res_valid        = 1'b1;
        res.status       = in_payload_r ? ST_TRUNC : ST_EOL;
      end else if (!in_payload_r) begin
        if (!header_count_r[2]) begin
          record_length_nxt = (record_length_r & ~(32'hFF << sh))
                              | ({24'd0, data_byte} << sh);
        end else begin
          stored_crc_nxt = (stored_crc_r & ~(32'hFF << sh))
                           | ({24'd0, data_byte} << sh);
        end
        header_count_nxt = header_count_r + 1'b1;
        // last header byte: length is already complete
        if (header_count_r == '1) begin
          if (record_length_r == '0 || record_length_r > lim) begin
            res_valid  = 1'b1;
            res.status = ST_SIZE;
          end else begin
            in_payload_nxt  = 1'b1;
            bytes_left_nxt  = record_length_r[LEN_W-1:0];
            running_crc_nxt = CRC_INIT;
          end
        end
      end else begin
        running_crc_nxt   = crc_upd;
        bytes_left_nxt    = bytes_left_r - 1'b1;
        res_valid         = 1'b1;
        res.payload_byte  = data_byte;
        res.payload_valid = 1'b1;
        res.record_end    = 1'b0;
        if (bytes_left_r == LEN_W'(1)) begin
          in_payload_nxt = 1'b0;
          res.record_end = 1'b1;
          if (~crc_upd == stored_crc_r) begin
            res.status = ST_OK;
          end else begin
            res.status = cfg.skip_corrupt ? ST_SKIPPED : ST_CRC;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r    <= 1'b0;
      header_count_r  <= '0;
      record_length_r <= '0;
      stored_crc_r    <= '0;
      running_crc_r   <= CRC_INIT;
      bytes_left_r    <= '0;
    end else begin
      in_payload_r    <= in_payload_nxt;
      header_count_r  <= header_count_nxt;
      record_length_r <= record_length_nxt;
      stored_crc_r    <= stored_crc_nxt;
      running_crc_r   <= running_crc_nxt;
      bytes_left_r    <= bytes_left_nxt;
    end
  end

  // a payload always has at least one byte still to come
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> bytes_left_r != '0)
    else $error("payload state with zero bytes left");

  // only payload bytes may leave record_end low
  a_end_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.payload_valid |-> res.record_end)
    else $error("event result without record_end");

  // end of log always restarts header parsing
  a_eol_restart: assert property (@(posedge clk) disable iff (!rst_n)
    word_fire && mode == MODE_EOL |=> !in_payload_r && header_count_r == '0)
    else $error("parser not back at header after end of log");

endmodule

// ===== design/lrd_out_skid.sv =====
// ----------------------------------------------------------------------------
// lrd_out_skid
// two-entry result buffer: output register plus skid stage
// ----------------------------------------------------------------------------
module lrd_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lrd_pkg::lrd_result_t push_data,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lrd_pkg::lrd_result_t out_data
);
  import lrd_pkg::*;

  logic        out_valid_r, skid_valid_r;
  lrd_result_t out_data_r, skid_data_r;
  logic        pop;

  assign pop        = out_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  // the skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // no result may arrive while both entries are taken
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full buffer");

  // a full skid stage moves up as soon as the output drains
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> out_valid_r && !skid_valid_r)
    else $error("skid entry lost on drain");

endmodule

// ===== design/log_record_deframer.sv =====
// ----------------------------------------------------------------------------
// log_record_deframer
// splits a log byte stream into length / crc-32c framed records
// ----------------------------------------------------------------------------
//
//  port group | direction | carries
//  -----------+-----------+-----------------------------------------------
//  in_*       | sink      | one log byte, or an end-of-log marker
//  out_*      | source    | payload byte or record / stream status
//  p*         | apb slave | max_record_bytes at 0x0, skip_corrupt at 0x4
//
//  one word is taken per cycle while in_tready is high; every word is parsed in the cycle it is
//  accepted and its result, if any, is registered for the output side
//  the crc-32c byte update (eight xor steps) and the length compare set the
//  critical combinational path
//  a two-entry output buffer lets a word in while a result waits; in_tready
//  drops only when both entries are full
//  rst_n is synchronous: parser returns to header state, crc to all ones,
//  registers to their defaults (16777216 and 0)
//
module log_record_deframer #(
  parameter int unsigned MAX_RECORD_LIMIT = lrd_pkg::MAX_RECORD_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lrd_pkg::DATA_W-1:0]         in_tdata,   // [7:0] data_byte
  input  logic [lrd_pkg::IN_USER_W-1:0]      in_tuser,   // [0] mode
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lrd_pkg::DATA_W-1:0]         out_tdata,  // [7:0] payload_byte
  output logic [lrd_pkg::OUT_USER_W-1:0]     out_tuser,  // [0] payload_valid, [3:1] status
  output logic                               out_tlast,  // record_end
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lrd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lrd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lrd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import lrd_pkg::*;

  logic                 rd_max_sel;
  logic [MAX_CFG_W-1:0] max_record_bytes_r;
  logic                 skip_corrupt_r;
  logic                 cfg_wr;
  lrd_cfg_t             cfg;

  logic        word_fire;
  logic        res_valid;
  lrd_result_t res;
  lrd_result_t out_res;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_record_bytes_r <= MAX_CFG_W'(MAX_RECORD_DEFAULT);
      skip_corrupt_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_RECORD: max_record_bytes_r <= pwdata[MAX_CFG_W-1:0];
        REG_SKIP:       skip_corrupt_r     <= pwdata[0];
        default:        ;
      endcase
    end
  end

  // register select for the read mux
  assign rd_max_sel = (paddr[2] == REG_MAX_RECORD);

  always_comb begin
    if (rd_max_sel) begin
      prdata = {{(CFG_DATA_W-MAX_CFG_W){1'b0}}, max_record_bytes_r};
    end else begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, skip_corrupt_r};
    end
  end

  assign cfg = '{max_record_bytes: max_record_bytes_r, skip_corrupt: skip_corrupt_r};

  // ---- parse one word per accepted beat ----
  assign word_fire = in_tvalid && in_tready;

  lrd_parser #(
    .MAX_RECORD_LIMIT (MAX_RECORD_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_fire (word_fire),
    .mode      (in_tuser[0]),
    .data_byte (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // ---- result buffer decouples the two stream sides ----
  lrd_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = out_res.payload_byte;
  assign out_tuser = {out_res.status, out_res.payload_valid};
  assign out_tlast = out_res.record_end;

  // forwarded bytes never carry a stream event status
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.payload_valid |->
      out_res.status == ST_OK || out_res.status == ST_CRC ||
      out_res.status == ST_SKIPPED)
    else $error("payload byte with event status");

  // a non-final payload byte always reports ok
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_res.payload_valid && out_res.status == ST_OK)
    else $error("mid-record result not a clean payload byte");

  // a config write takes effect on the next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && paddr[2] == REG_SKIP |=> skip_corrupt_r == $past(pwdata[0]))
    else $error("skip_corrupt not written");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the log record deframer: a scoreboard predicts
// every result word from the accepted input words, stream tasks feed framed
// records, broken headers and end-of-log markers under several register
// settings, with random idle on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrd_pkg::*;

  typedef logic [7:0] byte_q[$];

  // generous bound on the whole run, far above the slowest legal schedule
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // output hold-off that fills the result buffer and back-pressures the input
  localparam int unsigned STALL_CYCLES = 300;
  // settle time after the last expected word (registered output, two deep)
  localparam int unsigned SETTLE_CYCLES = 8;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of parser state and registers, queue of the words
  // still owed by the block
  // --------------------------------------------------------------------------
  class deframe_scoreboard;
    logic [MAX_CFG_W-1:0] max_bytes;
    bit                   skip_on;
    bit                   in_body;
    int unsigned          hdr_pos;
    logic [31:0]          rec_len;
    logic [31:0]          rec_crc;
    logic [31:0]          crc_acc;
    logic [MAX_CFG_W-1:0] remaining;
    lrd_result_t          expected_results[$];
    int unsigned          fail_count;

    function new();
      max_bytes = MAX_CFG_W'(MAX_RECORD_DEFAULT);
      skip_on   = 1'b0;
      in_body   = 1'b0;
      hdr_pos   = 0;
      rec_len   = '0;
      rec_crc   = '0;
      crc_acc   = CRC_INIT;
      remaining = '0;
      fail_count = 0;
    endfunction

    // bit-serial castagnoli update, lsb of the byte first
    static function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
      logic [31:0] v;
      logic        fb;
      v = acc;
      for (int k = 0; k < 8; k++) begin
        fb = v[0] ^ b[k];
        v  = v >> 1;
        if (fb) v = v ^ CRC_POLY;
      end
      return v;
    endfunction

    // register values above the built-in ceiling act as the ceiling
    static function logic [31:0] effective_limit(logic [MAX_CFG_W-1:0] m);
      return (32'(m) > MAX_RECORD_DEFAULT) ? 32'(MAX_RECORD_DEFAULT) : 32'(m);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
    endfunction

    // predict the result (if any) of one accepted input word
    function void note_word(logic mode, logic [7:0] b);
      lrd_result_t r;
      logic [31:0] lim;
      r = '0;
      if (mode == MODE_EOL) begin
        r.record_end = 1'b1;
        r.status     = in_body ? ST_TRUNC : ST_EOL;
        in_body   = 1'b0;
        hdr_pos   = 0;
        remaining = '0;
        expected_results.push_back(r);
        return;
      end
      if (!in_body) begin
        if (hdr_pos < 4) rec_len[8*hdr_pos +: 8] = b;
        else             rec_crc[8*(hdr_pos-4) +: 8] = b;
        if (hdr_pos < 7) begin
          hdr_pos++;
          return;
        end
        hdr_pos = 0;
        lim = effective_limit(max_bytes);
        if (rec_len == 0 || rec_len > lim) begin
          r.record_end = 1'b1;
          r.status     = ST_SIZE;
          expected_results.push_back(r);
          return;
        end
        in_body   = 1'b1;
        remaining = rec_len[MAX_CFG_W-1:0];
        crc_acc   = CRC_INIT;
        return;
      end
      crc_acc = crc_step(crc_acc, b);
      if (remaining > 0) remaining--;
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
      if (remaining == 0) begin
        in_body      = 1'b0;
        r.record_end = 1'b1;
        if (~crc_acc == rec_crc) r.status = ST_OK;
        else                     r.status = skip_on ? ST_SKIPPED : ST_CRC;
      end
      expected_results.push_back(r);
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(logic [7:0] tdata, logic [3:0] tuser, logic tlast);
      lrd_result_t exp_r;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected word data=%02h user=%h last=%b", tdata, tuser, tlast));
        return;
      end
      exp_r = expected_results.pop_front();
      if (tdata !== exp_r.payload_byte)
        report($sformatf("payload_byte %02h, want %02h", tdata, exp_r.payload_byte));
      if (tuser[0] !== exp_r.payload_valid)
        report($sformatf("payload_valid %b, want %b", tuser[0], exp_r.payload_valid));
      if (tlast !== exp_r.record_end)
        report($sformatf("record_end %b, want %b", tlast, exp_r.record_end));
      if (tuser[3:1] !== exp_r.status)
        report($sformatf("status %0d, want %0d", tuser[3:1], exp_r.status));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;   // [7:0] data_byte
  logic [IN_USER_W-1:0]  in_tuser   = '0;   // [0] mode

  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;         // [7:0] payload_byte
  logic [OUT_USER_W-1:0] out_tuser;         // [0] payload_valid, [3:1] status
  logic                  out_tlast;         // record_end

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // idle switches per phase, and the one-off request for a long output stall
  bit          in_idle_on    = 1'b0;
  bit          out_idle_on   = 1'b0;
  bit          stall_request = 1'b0;
  int unsigned words_sent    = 0;
  int unsigned cycle_count   = 0;

  deframe_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  log_record_deframer #(
    .MAX_RECORD_LIMIT(MAX_RECORD_DEFAULT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d result words outstanding", sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result monitor, values sampled as they stood at the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata, out_tuser, out_tlast);
  end

  // with idling on, half the words go straight through and the rest wait a random idle gap
  function automatic int unsigned idle_cycles(bit on);
    if (!on || $urandom_range(1, 0) == 0) return 0;
    return $urandom_range(17, 1);
  endfunction

  // --------------------------------------------------------------------------
  // receiver: random ready pattern, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  initial begin
    int unsigned wait_n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      wait_n = idle_cycles(out_idle_on);
      if (stall_request) begin
        wait_n        = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one word, optionally after an idle gap; note it once accepted
  task automatic send_word(input logic mode, input logic [7:0] b);
    int unsigned gap;
    gap = idle_cycles(in_idle_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    sb.note_word(mode, b);
    words_sent++;
  endtask

  // 4-byte length then 4-byte crc, both little-endian
  task automatic send_header(input logic [31:0] len, input logic [31:0] crc);
    for (int i = 0; i < 4; i++) send_word(MODE_DATA, len[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_word(MODE_DATA, crc[8*i +: 8]);
  endtask

  function automatic byte_q random_payload(int unsigned n);
    byte_q q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255, 0)));
    return q;
  endfunction

  // a payload shorter than len ends with an end-of-log word (truncation)
  task automatic send_record(input logic [31:0] len, input byte_q body, input bit corrupt);
    logic [31:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) crc = deframe_scoreboard::crc_step(crc, body[i]);
    crc = ~crc;
    if (corrupt)
      crc ^= $urandom_range(1, 0) ? (32'h1 << $urandom_range(31, 0)) : ($urandom | 32'h1);
    if (body.size() < len) crc = $urandom;
    send_header(len, crc);
    foreach (body[i]) send_word(MODE_DATA, body[i]);
    if (body.size() < len) send_word(MODE_EOL, 8'($urandom_range(255, 0)));
  endtask

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    // return to idle before the next transfer
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [CFG_ADDR_W-1:0] a, output logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    // return to idle before the next transfer
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    apb_read({REG_MAX_RECORD, 2'b00}, rd);
    if (rd !== {7'd0, sb.max_bytes})
      sb.report($sformatf("max_record_bytes reads %h, want %h", rd, sb.max_bytes));
    apb_read({REG_SKIP, 2'b00}, rd);
    if (rd !== {31'd0, sb.skip_on})
      sb.report($sformatf("skip_corrupt reads %h, want %b", rd, sb.skip_on));
  endtask

  // stop offering, wait for every owed word, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers change only with the block idle; unused upper bits carry noise
  task automatic set_config(input logic [MAX_CFG_W-1:0] max_val, input bit skip_val);
    drain();
    apb_write({REG_MAX_RECORD, 2'b00}, ($urandom & 32'hFE00_0000) | {7'd0, max_val});
    sb.max_bytes = max_val;
    apb_write({REG_SKIP, 2'b00}, ($urandom & 32'hFFFF_FFFE) | {31'd0, skip_val});
    sb.skip_on = skip_val;
    check_registers();
  endtask

  // one register setting, then a random mix of mostly well-formed records
  task automatic run_phase(input logic [MAX_CFG_W-1:0] max_val, input bit skip_val,
                           input int unsigned n_words, input bit in_on, input bit out_on);
    logic [31:0] lim;
    logic [31:0] len;
    int unsigned stop_at;
    int unsigned pick;
    int unsigned short_max;
    byte_q       body;
    set_config(max_val, skip_val);
    in_idle_on  = in_on;
    out_idle_on = out_on;
    lim       = deframe_scoreboard::effective_limit(max_val);
    short_max = (lim < 16) ? lim : 16;
    stop_at   = words_sent + n_words;
    while (words_sent < stop_at) begin
      // with a zero limit every header fails, so only header-level cases make sense
      pick = (lim == 0) ? $urandom_range(99, 83) : $urandom_range(99, 0);
      if (pick < 55) begin
        // good record
        body = random_payload($urandom_range(short_max, 1));
        send_record(body.size(), body, 1'b0);
      end else if (pick < 70) begin
        // checksum mismatch
        body = random_payload($urandom_range(short_max, 1));
        send_record(body.size(), body, 1'b1);
      end else if (pick < 78) begin
        // end of log inside the payload
        len = $urandom_range(short_max, 1);
        send_record(len, random_payload($urandom_range(len - 1, 0)), 1'b0);
      end else if (pick < 83) begin
        // length exactly at the limit; large limits are cut short
        if (lim <= 24) begin
          body = random_payload(lim);
          send_record(lim, body, $urandom_range(1, 0));
        end else begin
          send_record(lim, random_payload($urandom_range(5, 0)), 1'b0);
        end
      end else if (pick < 88) begin
        // zero length
        send_header(32'd0, $urandom);
      end else if (pick < 93) begin
        // oversized length, just above the limit or anywhere in 32 bits
        len = $urandom_range(1, 0) ? lim + 1 : $urandom;
        if (len <= lim) len = lim + 1;
        send_header(len, $urandom);
      end else if (pick < 99) begin
        // partial header (possibly empty) dropped by end of log
        repeat ($urandom_range(7, 0)) send_word(MODE_DATA, 8'($urandom_range(255, 0)));
        send_word(MODE_EOL, 8'($urandom_range(255, 0)));
      end else begin
        // noise of random kinds, then end of log to realign
        repeat ($urandom_range(6, 1))
          send_word(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
        send_word(MODE_EOL, 8'($urandom_range(255, 0)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_q edge_body;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of both registers
    check_registers();

    // directed: end of log at idle with a data byte that must be ignored,
    // a two-byte record with extreme payload bytes, an all-ones length,
    // and a partial header dropped by end of log
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    send_word(MODE_EOL, 8'hFF);
    edge_body = '{8'h00, 8'hFF};
    send_record(32'd2, edge_body, 1'b0);
    send_header(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(MODE_DATA, 8'h01);
    send_word(MODE_DATA, 8'h00);
    send_word(MODE_DATA, 8'h00);
    send_word(MODE_EOL, 8'h00);

    // back-pressure: long output hold-off while the sender streams a record
    drain();
    in_idle_on    = 1'b0;
    out_idle_on   = 1'b0;
    stall_request = 1'b1;
    send_record(32'd60, random_payload(60), 1'b0);

    // register sweep, extremes included: ceiling, one, clamped all-ones, zero
    run_phase(MAX_CFG_W'(MAX_RECORD_DEFAULT), 1'b1, 120, 1'b1, 1'b1);
    run_phase(MAX_CFG_W'(1), 1'b0, 80, 1'b0, 1'b1);
    run_phase(MAX_CFG_W'(MAX_CFG_VALUE), 1'b1, 120, 1'b1, 1'b0);
    run_phase(MAX_CFG_W'(0), 1'b0, 40, 1'b1, 1'b1);
    run_phase(MAX_CFG_W'($urandom_range(40, 2)), 1'($urandom_range(1, 0)), 120, 1'b0, 1'b0);
    run_phase(MAX_CFG_W'($urandom_range(40, 2)), 1'($urandom_range(1, 0)), 120, 1'b1, 1'b1);
    run_phase(MAX_CFG_W'(16), 1'b0, 120, 1'b1, 1'b0);
    run_phase(MAX_CFG_W'($urandom_range(MAX_CFG_VALUE, 1)), 1'($urandom_range(1, 0)),
              120, 1'b0, 1'b1);
    run_phase(MAX_CFG_W'(MAX_RECORD_DEFAULT), 1'b0, 120, 1'b1, 1'b1);

    drain();
    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
